// ===== rtl/core/hall_key_actuation_engine_defines.svh =====
// Assertion helpers shared by the engine RTL
`ifndef HALL_KEY_ACTUATION_ENGINE_DEFINES_SVH
`define HALL_KEY_ACTUATION_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HKAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define HKAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hkae_pkg.sv =====
`timescale 1ns / 1ps
package hkae_pkg;

  localparam int KEYS       = 128;
  localparam int KEY_W      = $clog2(KEYS);
  localparam int TRAVEL_W   = 7;
  localparam int RAW_W      = 16;
  localparam int DIV_STEPS  = TRAVEL_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int NUM_W      = RAW_W + TRAVEL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [TRAVEL_W-1:0] TRAVEL_FULL = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_DEBOUNCE     = 3'd1,
    CFG_HYSTERESIS   = 3'd2,
    CFG_CANCEL_FIRST = 3'd3,
    CFG_CANCEL_SECOND = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,
    MODE_RAPID  = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PACT_NONE  = 2'd0,
    PACT_CLEAR = 2'd1,
    PACT_SET   = 2'd2
  } pact_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_UPD
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key_index;
    logic [RAW_W-1:0]    raw_sample;
    logic [RAW_W-1:0]    rest_raw;
    logic [RAW_W-1:0]    full_raw;
    logic [TRAVEL_W-1:0] actuation_level;
    logic [TRAVEL_W-1:0] release_level;
    logic [7:0]          deadzone;
    logic [7:0]          press_margin;
    logic [7:0]          lift_margin;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key_out;
    logic [TRAVEL_W-1:0] travel;
    logic                changed;
    logic                report_bit;
    logic [KEY_W-1:0]    partner_key;
    logic [1:0]          partner_action;
  } out_item_t;

  typedef struct packed {
    logic [7:0] counter;
    logic [7:0] boundary;
  } key_rec_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [TRAVEL_W-1:0] quotient;
  } div_stat_t;

endpackage

// ===== rtl/core/hkae_div.sv =====
`timescale 1ns / 1ps
module hkae_div
  import hkae_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [RAW_W-1:0] divisor,
  output div_stat_t        stat
);

  logic [NUM_W-1:0]    rem_r, rem_nxt;
  logic [RAW_W-1:0]    den_r, den_nxt;
  logic [TRAVEL_W-1:0] q_r, q_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [NUM_W-1:0]    trial;

  // quotient fits in TRAVEL_W bits, so the shifted divisor never overflows
  assign trial = NUM_W'(den_r) << step_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      den_nxt  = divisor;
      q_nxt    = '0;
      step_nxt = STEP_W'(DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt        = rem_r - trial;
        q_nxt[step_r]  = 1'b1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat = '{busy: busy_r, done: done_r, quotient: q_r};

endmodule

// ===== rtl/core/hkae_keymem.sv =====
`timescale 1ns / 1ps
module hkae_keymem
  import hkae_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_addr,
  output key_rec_t         rd_data,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_addr,
  input  key_rec_t         wr_data
);

  key_rec_t          mem [KEYS];
  logic [KEYS-1:0]   vld_r;
  key_rec_t          q_r;
  logic              qv_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        qv_r <= vld_r[rd_addr];
      end
    end
  end

  // entry never written reads as cleared
  assign rd_data = qv_r ? q_r : '0;

endmodule

// ===== rtl/core/hall_key_actuation_engine.sv =====
`timescale 1ns / 1ps
// Hall-effect key actuation engine.
// Input channel (in_valid/in_ready/in_data): one raw sample of one key with its
// calibration and thresholds. Result channel (out_valid/out_ready/out_data):
// exactly one result per request, in order: travel 0..100, changed flag, the
// key's report bit and any partner update made by key cancellation.
// Configuration: cfg_we/cfg_index/cfg_wdata, which the user must write only
// while idle; the block itself does not enforce this. A request passes S_MUL
// and S_UPD when travel is saturated or the calibration is degenerate, and
// S_MUL, S_DIVGO, S_DIV and S_UPD when the scaling divide runs. The divide is a
// restoring divider that retires one quotient bit per cycle through one shared
// subtractor, seven bits in all. in_ready is high only while the sequencer idles.
// Per-key counter and boundary sit in a 128-entry memory with valid bits;
// debounced and report bits are flip-flops.
// Reset (rst_n, synchronous, active low) clears all key state at once and
// loads the default registers; no clearing pass is needed.
// A result waits in the output register while the receiver stalls; the next
// request is still taken and processed up to its state commit, which holds
// until the output register is free.
`include "hall_key_actuation_engine_defines.svh"
module hall_key_actuation_engine
  import hkae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t              state_r, state_nxt;
  in_item_t            in_r;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [RAW_W-1:0]    den_r, den_nxt;
  logic [TRAVEL_W-1:0] t_r, t_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [1:0]          mode_r;
  logic [7:0]          dbc_r;
  logic [6:0]          hyst_r;
  logic [KEY_W-1:0]    cfk_r, csk_r;

  logic [KEYS-1:0]     deb_r, deb_nxt;
  logic [KEYS-1:0]     rb_r, rb_nxt;
  logic [KEY_W-1:0]    lp_r, lp_nxt;
  logic                fh_r, fh_nxt, sh_r, sh_nxt;

  logic                accept, commit, div_start;
  div_stat_t           div_stat;
  key_rec_t            rec_rd, rec_wr;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign commit    = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign div_start = (state_r == S_DIVGO);

  hkae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .stat     (div_stat)
  );

  hkae_keymem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_data.key_index),
    .rd_data (rec_rd),
    .wr_en   (commit),
    .wr_addr (in_r.key_index),
    .wr_data (rec_wr)
  );

  // sequencer and scaling front end
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    t_nxt     = t_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_MUL;
      end
      S_MUL: begin
        num_nxt = NUM_W'(in_r.rest_raw - in_r.raw_sample) * NUM_W'(TRAVEL_FULL);
        den_nxt = in_r.rest_raw - in_r.full_raw;
        if (in_r.full_raw >= in_r.rest_raw ||
            in_r.raw_sample >= in_r.rest_raw) begin
          t_nxt     = '0;
          state_nxt = S_UPD;
        end else if (in_r.raw_sample <= in_r.full_raw) begin
          t_nxt     = TRAVEL_FULL;
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          t_nxt     = div_stat.quotient;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // actuation update
  always_comb begin
    logic [KEY_W-1:0] k;
    logic             deb;
    logic [7:0]       cnt1;
    logic             fire;
    logic [8:0]       ti, h, dz, b, eng, dis;
    logic             kw, kval;
    logic [KEY_W-1:0] p;
    logic             pfound;

    k      = in_r.key_index;
    deb    = deb_r[k];
    cnt1   = rec_rd.counter + 8'd1;
    fire   = (cnt1 >= dbc_r);
    ti     = 9'(t_r);
    h      = 9'(hyst_r);
    dz     = 9'(in_r.deadzone);
    b      = 9'(rec_rd.boundary);
    eng    = 9'(in_r.press_margin);
    dis    = 9'(in_r.lift_margin);
    kw     = 1'b0;
    kval   = 1'b0;
    p      = '0;
    pfound = 1'b0;

    deb_nxt = deb_r;
    rb_nxt  = rb_r;
    lp_nxt  = lp_r;
    fh_nxt  = fh_r;
    sh_nxt  = sh_r;
    rec_wr  = rec_rd;
    out_nxt = '{key_out: k, travel: t_r, changed: 1'b0, report_bit: 1'b0,
                partner_key: '0, partner_action: PACT_NONE};

    unique case (mode_t'(mode_r))
      MODE_FIXED: begin
        if (t_r > in_r.actuation_level && !deb) begin
          rec_wr.counter = cnt1;
          if (fire) begin
            deb_nxt[k] = 1'b1; kw = 1'b1; kval = 1'b1;
            rec_wr.counter = '0; out_nxt.changed = 1'b1;
          end
        end else if (t_r < in_r.release_level && deb) begin
          deb_nxt[k] = 1'b0; kw = 1'b1; kval = 1'b0;
          rec_wr.counter = '0; out_nxt.changed = 1'b1;
        end else begin
          rec_wr.counter = '0;
        end
      end
      MODE_RAPID: begin
        if (ti + h <= dz) begin
          // deadzone forces a release, even when already released
          deb_nxt[k] = 1'b0; rec_wr.boundary = in_r.deadzone;
          kw = 1'b1; kval = 1'b0; rec_wr.counter = '0; out_nxt.changed = 1'b1;
        end else if (ti > dz + h) begin
          if (ti > b + eng) begin
            if (!deb) begin
              rec_wr.counter = cnt1;
              if (fire) begin
                deb_nxt[k] = 1'b1; rec_wr.boundary = 8'(t_r);
                kw = 1'b1; kval = 1'b1; rec_wr.counter = '0; out_nxt.changed = 1'b1;
              end
            end else if (ti > b + h) begin
              rec_wr.boundary = 8'(t_r);
            end
          end else if (ti + dis < b && deb) begin
            rec_wr.counter = cnt1;
            if (fire) begin
              deb_nxt[k] = 1'b0;
              rec_wr.boundary = 8'(t_r) + in_r.press_margin;
              kw = 1'b1; kval = 1'b0; rec_wr.counter = '0; out_nxt.changed = 1'b1;
            end
          end else begin
            rec_wr.counter = '0;
          end
        end
      end
      MODE_CANCEL: begin
        if (t_r > in_r.actuation_level && !deb) begin
          rec_wr.counter = cnt1;
          if (fire) begin
            if (k == cfk_r) fh_nxt = 1'b1;
            if (k == csk_r) sh_nxt = 1'b1;
            if ((k == csk_r && lp_r == cfk_r) || (k == cfk_r && lp_r == csk_r)) begin
              p = (k == csk_r) ? cfk_r : csk_r;
              rb_nxt[p] = 1'b0;
              out_nxt.partner_key    = p;
              out_nxt.partner_action = PACT_CLEAR;
            end
            deb_nxt[k] = 1'b1; kw = 1'b1; kval = 1'b1;
            rec_wr.counter = '0; lp_nxt = k; out_nxt.changed = 1'b1;
          end
        end else if (t_r < in_r.release_level && deb) begin
          if (k == cfk_r) fh_nxt = 1'b0;
          if (k == csk_r) sh_nxt = 1'b0;
          deb_nxt[k] = 1'b0; kw = 1'b1; kval = 1'b0; rec_wr.counter = '0;
          if (lp_r == k) begin
            if (k == cfk_r && sh_nxt) begin
              p = csk_r; pfound = 1'b1;
            end else if (k == csk_r && fh_nxt) begin
              p = cfk_r; pfound = 1'b1;
            end
            if (pfound) begin
              out_nxt.partner_key    = p;
              out_nxt.partner_action = PACT_SET;
              lp_nxt = p;
            end else begin
              lp_nxt = '0;
            end
          end
          out_nxt.changed = 1'b1;
        end else begin
          rec_wr.counter = '0;
        end
      end
      MODE_NONE: begin
      end
      default: begin
      end
    endcase

    // key's own bit overrides a partner clear on the same key
    if (kw) rb_nxt[k] = kval;
    if (pfound) rb_nxt[p] = 1'b1;
    out_nxt.report_bit = kw ? kval : rb_r[k];
  end

  assign out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    t_r   <= t_nxt;
    if (accept) in_r <= in_data;
    if (commit) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      deb_r       <= '0;
      rb_r        <= '0;
      lp_r        <= '0;
      fh_r        <= 1'b0;
      sh_r        <= 1'b0;
      mode_r      <= MODE_FIXED;
      dbc_r       <= 8'd5;
      hyst_r      <= 7'd8;
      cfk_r       <= 7'd32;
      csk_r       <= 7'd34;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        deb_r <= deb_nxt;
        rb_r  <= rb_nxt;
        lp_r  <= lp_nxt;
        fh_r  <= fh_nxt;
        sh_r  <= sh_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MODE:          mode_r <= cfg_wdata[1:0];
          CFG_DEBOUNCE:      dbc_r  <= cfg_wdata;
          CFG_HYSTERESIS:    hyst_r <= cfg_wdata[6:0];
          CFG_CANCEL_FIRST:  cfk_r  <= cfg_wdata[KEY_W-1:0];
          CFG_CANCEL_SECOND: csk_r  <= cfg_wdata[KEY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `HKAE_ASSERT_NOW(a_idle_div_quiet, state_r == S_IDLE, !div_stat.busy, "divider busy while idle")
  `HKAE_ASSERT_NOW(a_done_in_div, div_stat.done, state_r == S_DIV, "divide finished outside wait state")
  `HKAE_ASSERT_NEXT(a_commit_shows, commit, out_valid_r && state_r == S_IDLE, "committed result not shown")
  `HKAE_ASSERT_NOW(a_partner_idle_zero, out_valid_r && out_r.partner_action == PACT_NONE, out_r.partner_key == '0, "partner key set without action")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import hkae_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hall_key_actuation_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // key model state
  logic       key_down [KEYS];
  logic [7:0] key_count [KEYS];
  logic [7:0] key_bound [KEYS];
  logic       key_report [KEYS];
  logic [6:0] last_key;
  logic       first_down, second_down;
  mode_t      cur_mode;
  logic [7:0] debounce_req;
  logic [6:0] hyst;
  logic [6:0] pair_first, pair_second;

  out_item_t  expected_q [$];
  int         errors;
  int         results_seen;
  int         requests_sent;
  longint     cycle_count;
  int         hold_off;
  logic       long_stall;
  int         stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic logic [6:0] scaled_travel(logic [15:0] s, logic [15:0] fl, logic [15:0] ce);
    logic [31:0] num;
    if (ce >= fl) return 7'd0;
    if (s >= fl) return 7'd0;
    if (s <= ce) return 7'd100;
    num = (32'(fl) - 32'(s)) * 32'd100;
    return 7'(num / (32'(fl) - 32'(ce)));
  endfunction

  function automatic logic bump_count(int k);
    key_count[k] = key_count[k] + 8'd1;
    return key_count[k] >= debounce_req;
  endfunction

  function automatic out_item_t predict_actuation(in_item_t it);
    out_item_t r;
    int k, t, dz, eng, dis, h, b;
    int fk, sk, p;
    logic up, down;
    k = it.key_index;
    t = scaled_travel(it.raw_sample, it.rest_raw, it.full_raw);
    dz = it.deadzone; eng = it.press_margin; dis = it.lift_margin;
    r = '0;
    r.key_out = it.key_index;
    r.travel = 7'(t);
    r.partner_action = PACT_NONE;
    if (cur_mode == MODE_FIXED || cur_mode == MODE_CANCEL) begin
      fk = pair_first; sk = pair_second;
      if (t > it.actuation_level && !key_down[k]) begin
        if (bump_count(k)) begin
          if (cur_mode == MODE_CANCEL) begin
            if (k == fk) first_down = 1'b1;
            if (k == sk) second_down = 1'b1;
            if ((k == sk && last_key == fk) || (k == fk && last_key == sk)) begin
              p = (k == sk) ? fk : sk;
              key_report[p] = 1'b0;
              r.partner_key = 7'(p);
              r.partner_action = PACT_CLEAR;
            end
            last_key = 7'(k);
          end
          key_down[k] = 1'b1; key_report[k] = 1'b1; key_count[k] = '0; r.changed = 1'b1;
        end
      end else if (t < it.release_level && key_down[k]) begin
        key_down[k] = 1'b0; key_report[k] = 1'b0; key_count[k] = '0; r.changed = 1'b1;
        if (cur_mode == MODE_CANCEL) begin
          if (k == fk) first_down = 1'b0;
          if (k == sk) second_down = 1'b0;
          if (last_key == k) begin
            p = -1;
            if (k == fk && second_down) p = sk;
            else if (k == sk && first_down) p = fk;
            if (p >= 0) begin
              key_report[p] = 1'b1;
              r.partner_key = 7'(p);
              r.partner_action = PACT_SET;
              last_key = 7'(p);
            end else begin
              last_key = '0;
            end
          end
        end
      end else begin
        key_count[k] = '0;
      end
    end else if (cur_mode == MODE_RAPID) begin
      h = hyst; b = key_bound[k];
      if (t <= dz - h) begin
        key_down[k] = 1'b0; key_bound[k] = 8'(dz); key_report[k] = 1'b0;
        key_count[k] = '0; r.changed = 1'b1;
      end else if (t > dz + h) begin
        up = t > b + eng;
        down = t < b - dis;
        if (up) begin
          if (!key_down[k]) begin
            if (bump_count(k)) begin
              key_down[k] = 1'b1; key_bound[k] = 8'(t); key_report[k] = 1'b1;
              key_count[k] = '0; r.changed = 1'b1;
            end
          end else if (t > b + h) begin
            key_bound[k] = 8'(t);
          end
        end else if (down && key_down[k]) begin
          if (bump_count(k)) begin
            key_down[k] = 1'b0; key_bound[k] = 8'(t + eng); key_report[k] = 1'b0;
            key_count[k] = '0; r.changed = 1'b1;
          end
        end else begin
          key_count[k] = '0;
        end
      end
    end
    r.report_bit = key_report[k];
    return r;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (long_stall) begin
      out_ready <= 1'b0;
      hold_off <= hold_off + 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result key", out_data.key_out, -1);
      end else begin
        want = expected_q.pop_front();
        if (out_data.key_out !== want.key_out)
          report_mismatch("key_out", out_data.key_out, want.key_out);
        if (out_data.travel !== want.travel)
          report_mismatch("travel", out_data.travel, want.travel);
        if (out_data.changed !== want.changed)
          report_mismatch("changed", out_data.changed, want.changed);
        if (out_data.report_bit !== want.report_bit)
          report_mismatch("report_bit", out_data.report_bit, want.report_bit);
        if (out_data.partner_key !== want.partner_key)
          report_mismatch("partner_key", out_data.partner_key, want.partner_key);
        if (out_data.partner_action !== want.partner_action)
          report_mismatch("partner_action", out_data.partner_action, want.partner_action);
      end
      results_seen++;
    end
  end

  // valid stays up between back-to-back requests; drop it only over a gap
  task automatic send_sample(input in_item_t it, input bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_actuation(it));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    // hold the write until nothing is in flight
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:          cur_mode = mode_t'(val[1:0]);
      CFG_DEBOUNCE:      debounce_req = val;
      CFG_HYSTERESIS:    hyst = val[6:0];
      CFG_CANCEL_FIRST:  pair_first = val[6:0];
      CFG_CANCEL_SECOND: pair_second = val[6:0];
      default: ;
    endcase
  endtask

  // sample with a travel chosen through raw reading over a simple calibration
  function automatic in_item_t keyed_sample(int k, int pct, int act, int rel);
    in_item_t it;
    it = '0;
    it.key_index = 7'(k);
    it.rest_raw = 16'd2000;
    it.full_raw = 16'd1000;
    it.raw_sample = 16'(2000 - pct * 10);
    it.actuation_level = 7'(act);
    it.release_level = 7'(rel);
    it.deadzone = 8'($urandom_range(0, 20));
    it.press_margin = 8'($urandom_range(0, 15));
    it.lift_margin = 8'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic in_item_t noise_sample();
    in_item_t it;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    it.actuation_level = 7'($urandom_range(0, 127));
    it.release_level = 7'($urandom_range(0, 127));
    return it;
  endfunction

  task automatic test_scaling_extremes();
    in_item_t it;
    it = '0; send_sample(it);
    it = '1; send_sample(it);
    it = '0; it.rest_raw = 16'hFFFF; it.raw_sample = 16'h0001; it.key_index = 7'd127;
    send_sample(it);
    it.full_raw = 16'hFFFF; send_sample(it);
    it = '0; it.rest_raw = 16'd100; it.full_raw = 16'd99; it.raw_sample = 16'd99;
    send_sample(it);
    it.raw_sample = 16'd100; send_sample(it);
    it = '0; it.rest_raw = 16'hFFFF; it.full_raw = 16'd0; it.raw_sample = 16'd1;
    it.actuation_level = 7'd100; it.release_level = 7'd100;
    send_sample(it);
    it.raw_sample = 16'hFFFE; it.deadzone = 8'hFF; it.press_margin = 8'hFF;
    it.lift_margin = 8'hFF; send_sample(it);
    wait_drained();
  endtask

  task automatic test_fixed_mode();
    write_reg(CFG_DEBOUNCE, 8'd2);
    repeat (3) send_sample(keyed_sample(5, 80, 50, 30));
    send_sample(keyed_sample(5, 10, 50, 30));
    // debounce of zero fires at once
    write_reg(CFG_DEBOUNCE, 8'd0);
    send_sample(keyed_sample(6, 90, 40, 20));
    send_sample(keyed_sample(6, 5, 40, 20));
    // no meaning for mode three
    write_reg(CFG_MODE, MODE_NONE);
    send_sample(keyed_sample(6, 90, 40, 20));
    wait_drained();
  endtask

  task automatic test_rapid_trigger();
    in_item_t it;
    write_reg(CFG_MODE, MODE_RAPID);
    write_reg(CFG_HYSTERESIS, 7'd0);
    write_reg(CFG_DEBOUNCE, 8'd1);
    send_sample(keyed_sample(9, 0, 0, 0));
    send_sample(keyed_sample(9, 60, 0, 0));
    send_sample(keyed_sample(9, 90, 0, 0));
    send_sample(keyed_sample(9, 40, 0, 0));
    // boundary wrap: travel plus engage beyond 255
    it = keyed_sample(9, 100, 0, 0);
    it.deadzone = 8'd0; it.press_margin = 8'd0; send_sample(it);
    it = keyed_sample(9, 50, 0, 0); it.deadzone = 8'd0;
    it.lift_margin = 8'd0; it.press_margin = 8'd250; send_sample(it);
    write_reg(CFG_HYSTERESIS, 7'd100);
    send_sample(keyed_sample(9, 100, 0, 0));
    wait_drained();
  endtask

  task automatic test_cancel_pair();
    write_reg(CFG_MODE, MODE_CANCEL);
    write_reg(CFG_DEBOUNCE, 8'd1);
    write_reg(CFG_CANCEL_FIRST, 7'd127);
    write_reg(CFG_CANCEL_SECOND, 7'd0);
    send_sample(keyed_sample(127, 90, 50, 30));
    send_sample(keyed_sample(0, 90, 50, 30));
    send_sample(keyed_sample(0, 5, 50, 30));
    send_sample(keyed_sample(127, 5, 50, 30));
    // same key in both registers
    write_reg(CFG_CANCEL_SECOND, 7'd127);
    send_sample(keyed_sample(127, 90, 50, 30));
    send_sample(keyed_sample(127, 5, 50, 30));
    wait_drained();
  endtask

  task automatic run_random_phase(input int count, input int nkeys, input int sel_mode);
    int k, pct, fk, sk, pick;
    fk = pair_first; sk = pair_second;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_sample(noise_sample());
      end else begin
        if (sel_mode == 2 && pick < 7) k = ($urandom_range(0, 1) != 0) ? fk : sk;
        else k = $urandom_range(0, nkeys - 1);
        pct = $urandom_range(0, 100);
        send_sample(keyed_sample(k, pct, $urandom_range(20, 70), $urandom_range(10, 60)));
      end
    end
    wait_drained();
  endtask

  task automatic test_random_modes();
    write_reg(CFG_MODE, MODE_FIXED);
    write_reg(CFG_DEBOUNCE, 8'd1);
    run_random_phase(120, 4, 0);
    write_reg(CFG_MODE, MODE_RAPID);
    write_reg(CFG_HYSTERESIS, 7'($urandom_range(0, 10)));
    write_reg(CFG_DEBOUNCE, 8'd2);
    run_random_phase(150, 4, 1);
    write_reg(CFG_MODE, MODE_CANCEL);
    write_reg(CFG_DEBOUNCE, 8'd1);
    write_reg(CFG_CANCEL_FIRST, 7'($urandom_range(0, 127)));
    write_reg(CFG_CANCEL_SECOND, 7'($urandom_range(0, 127)));
    run_random_phase(150, 8, 2);
    write_reg(CFG_DEBOUNCE, 8'd255);
    write_reg(CFG_MODE, MODE_FIXED);
    run_random_phase(60, 128, 0);
    write_reg(CFG_MODE, MODE_NONE);
    run_random_phase(20, 128, 0);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_MODE, MODE_FIXED);
    write_reg(CFG_DEBOUNCE, 8'd1);
    hold_off = 0;
    long_stall = 1'b1;
    fork
      for (int i = 0; i < 12; i++) send_sample(keyed_sample(i, 95, 50, 30), 1);
      begin
        while (hold_off < 200) @(posedge clk);
        long_stall = 1'b0;
      end
    join
    hold_off = -1;
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_wdata = '0;
    errors = 0; results_seen = 0; requests_sent = 0; cycle_count = 0;
    hold_off = -1; long_stall = 1'b0;
    for (int i = 0; i < KEYS; i++) begin
      key_down[i] = 1'b0; key_count[i] = '0; key_bound[i] = '0; key_report[i] = 1'b0;
    end
    last_key = '0; first_down = 1'b0; second_down = 1'b0;
    cur_mode = MODE_FIXED; debounce_req = 8'd5; hyst = 7'd8;
    pair_first = 7'd32; pair_second = 7'd34;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_scaling_extremes();
    test_fixed_mode();
    test_rapid_trigger();
    test_cancel_pair();
    test_backpressure();
    test_random_modes();
    $display("covered: %0d samples, %0d results over fixed, rapid trigger, cancel and idle modes",
             requests_sent, results_seen);
    $display("registers swept to extremes, including a long output hold-off");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
